// File: src/pvkdm_pkg.sv
// ----------------------------------------------------------------------------
// pvkdm_pkg
// Types, codes, saturation helpers and the microprogram of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pvkdm_pkg;

  typedef logic signed [63:0] wide_t;

  localparam wide_t WMAX = 64'sh2000_0000_0000_0000;
  localparam wide_t WMIN = -64'sh2000_0000_0000_0000;
  localparam wide_t S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t S32_MIN = -64'sh0000_0000_8000_0000;
  localparam wide_t U32_MAX = 64'sh0000_0000_FFFF_FFFF;
  localparam wide_t ONE_HALF = 64'sd32768;

  localparam logic [2:0] CFG_INPUT_SIGMA = 3'd0;
  localparam logic [2:0] CFG_MEAS_SIGMA  = 3'd1;
  localparam logic [2:0] CFG_DELAY       = 3'd2;
  localparam logic [2:0] CFG_INIT_POS    = 3'd3;
  localparam logic [2:0] CFG_INIT_VEL    = 3'd4;

  localparam logic [3:0] OP_MUL    = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_SATS   = 4'd4;
  localparam logic [3:0] OP_SATU   = 4'd5;
  localparam logic [3:0] OP_LDREF  = 4'd6;
  localparam logic [3:0] OP_RINGWR = 4'd7;
  localparam logic [3:0] OP_END    = 4'd8;

  localparam int NREG = 24;
  localparam logic [4:0] R_DT   = 5'd0;
  localparam logic [4:0] R_U    = 5'd1;
  localparam logic [4:0] R_Z    = 5'd2;
  localparam logic [4:0] R_HALF = 5'd3;
  localparam logic [4:0] R_SU   = 5'd4;
  localparam logic [4:0] R_SM   = 5'd5;
  localparam logic [4:0] R_G0   = 5'd6;
  localparam logic [4:0] R_T    = 5'd7;
  localparam logic [4:0] R_T2   = 5'd8;
  localparam logic [4:0] R_Q00  = 5'd9;
  localparam logic [4:0] R_Q01  = 5'd10;
  localparam logic [4:0] R_Q11  = 5'd11;
  localparam logic [4:0] R_POS  = 5'd12;
  localparam logic [4:0] R_VEL  = 5'd13;
  localparam logic [4:0] R_P00  = 5'd14;
  localparam logic [4:0] R_P01  = 5'd15;
  localparam logic [4:0] R_P10  = 5'd16;
  localparam logic [4:0] R_P11  = 5'd17;
  localparam logic [4:0] R_N01  = 5'd18;
  localparam logic [4:0] R_REF  = 5'd19;
  localparam logic [4:0] R_INN  = 5'd20;
  localparam logic [4:0] R_SV   = 5'd21;
  localparam logic [4:0] R_K0   = 5'd22;
  localparam logic [4:0] R_K1   = 5'd23;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    logic out_load;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic wide_t clampw(input wide_t x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  function automatic wide_t sats(input wide_t x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic wide_t satu(input wide_t x);
    if (x < 0) return '0;
    if (x > U32_MAX) return U32_MAX;
    return x;
  endfunction

  function automatic uop_t mk(input logic [3:0] op, input logic [4:0] a,
                              input logic [4:0] b, input logic [4:0] d);
    uop_t u;
    u.op = op;
    u.a = a;
    u.b = b;
    u.d = d;
    return u;
  endfunction

  function automatic uop_t prog(input logic [5:0] pc);
    case (pc)
      6'd0:  return mk(OP_MUL, R_DT, R_DT, R_T);
      6'd1:  return mk(OP_MUL, R_T, R_HALF, R_G0);
      6'd2:  return mk(OP_MUL, R_G0, R_G0, R_T);
      6'd3:  return mk(OP_MUL, R_T, R_SU, R_T);
      6'd4:  return mk(OP_MUL, R_T, R_SU, R_Q00);
      6'd5:  return mk(OP_MUL, R_G0, R_DT, R_T);
      6'd6:  return mk(OP_MUL, R_T, R_SU, R_T);
      6'd7:  return mk(OP_MUL, R_T, R_SU, R_Q01);
      6'd8:  return mk(OP_MUL, R_DT, R_DT, R_T);
      6'd9:  return mk(OP_MUL, R_T, R_SU, R_T);
      6'd10: return mk(OP_MUL, R_T, R_SU, R_Q11);
      6'd11: return mk(OP_MUL, R_DT, R_VEL, R_T);
      6'd12: return mk(OP_ADD, R_POS, R_T, R_T2);
      6'd13: return mk(OP_MUL, R_G0, R_U, R_T);
      6'd14: return mk(OP_ADD, R_T2, R_T, R_T2);
      6'd15: return mk(OP_SATS, R_T2, R_T2, R_POS);
      6'd16: return mk(OP_MUL, R_DT, R_U, R_T);
      6'd17: return mk(OP_ADD, R_VEL, R_T, R_T);
      6'd18: return mk(OP_SATS, R_T, R_T, R_VEL);
      6'd19: return mk(OP_MUL, R_DT, R_P11, R_T);
      6'd20: return mk(OP_ADD, R_P01, R_T, R_N01);
      6'd21: return mk(OP_MUL, R_DT, R_P10, R_T);
      6'd22: return mk(OP_ADD, R_P00, R_T, R_T2);
      6'd23: return mk(OP_MUL, R_DT, R_N01, R_T);
      6'd24: return mk(OP_ADD, R_T2, R_T, R_T2);
      6'd25: return mk(OP_ADD, R_T2, R_Q00, R_T2);
      6'd26: return mk(OP_MUL, R_DT, R_P11, R_T);
      6'd27: return mk(OP_ADD, R_P10, R_T, R_T);
      6'd28: return mk(OP_ADD, R_T, R_Q01, R_T);
      6'd29: return mk(OP_SATS, R_T, R_T, R_P10);
      6'd30: return mk(OP_ADD, R_N01, R_Q01, R_T);
      6'd31: return mk(OP_SATS, R_T, R_T, R_P01);
      6'd32: return mk(OP_ADD, R_P11, R_Q11, R_T);
      6'd33: return mk(OP_SATU, R_T, R_T, R_P11);
      6'd34: return mk(OP_SATU, R_T2, R_T2, R_P00);
      6'd35: return mk(OP_LDREF, R_POS, R_POS, R_REF);
      6'd36: return mk(OP_SUB, R_Z, R_REF, R_INN);
      6'd37: return mk(OP_MUL, R_SM, R_SM, R_T);
      6'd38: return mk(OP_ADD, R_P00, R_T, R_SV);
      6'd39: return mk(OP_DIV, R_P00, R_SV, R_K0);
      6'd40: return mk(OP_DIV, R_P10, R_SV, R_K1);
      6'd41: return mk(OP_MUL, R_K0, R_INN, R_T);
      6'd42: return mk(OP_ADD, R_POS, R_T, R_T);
      6'd43: return mk(OP_SATS, R_T, R_T, R_POS);
      6'd44: return mk(OP_MUL, R_K1, R_INN, R_T);
      6'd45: return mk(OP_ADD, R_VEL, R_T, R_T);
      6'd46: return mk(OP_SATS, R_T, R_T, R_VEL);
      6'd47: return mk(OP_MUL, R_K0, R_P00, R_T);
      6'd48: return mk(OP_SUB, R_P00, R_T, R_T2);
      6'd49: return mk(OP_MUL, R_K0, R_P01, R_T);
      6'd50: return mk(OP_SUB, R_P01, R_T, R_N01);
      6'd51: return mk(OP_MUL, R_K1, R_P00, R_T);
      6'd52: return mk(OP_SUB, R_P10, R_T, R_T);
      6'd53: return mk(OP_SATS, R_T, R_T, R_P10);
      6'd54: return mk(OP_MUL, R_K1, R_P01, R_T);
      6'd55: return mk(OP_SUB, R_P11, R_T, R_T);
      6'd56: return mk(OP_SATU, R_T, R_T, R_P11);
      6'd57: return mk(OP_SATU, R_T2, R_T2, R_P00);
      6'd58: return mk(OP_SATS, R_N01, R_N01, R_P01);
      6'd59: return mk(OP_RINGWR, R_POS, R_POS, R_POS);
      default: return mk(OP_END, R_POS, R_POS, R_POS);
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/pvkdm_if.sv
// ----------------------------------------------------------------------------
// pvkdm_in_if / pvkdm_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvkdm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_input;
  logic signed [31:0] measured_position;
  logic        [15:0] time_step;
  logic               restart;
  modport source (output valid, accel_input, measured_position, time_step, restart,
                  input ready);
  modport sink (input valid, accel_input, measured_position, time_step, restart,
                output ready);
endinterface

interface pvkdm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic        [31:0] pos_variance;
  logic        [31:0] vel_variance;
  logic               gain_fault;
  modport source (output valid, position, velocity, pos_variance, vel_variance,
                  gain_fault, input ready);
  modport sink (input valid, position, velocity, pos_variance, vel_variance,
                gain_fault, output ready);
endinterface

`default_nettype wire

// File: src/pvkdm_ram.sv
// ----------------------------------------------------------------------------
// pvkdm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pvkdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: src/pvkdm_ctrl.sv
// ----------------------------------------------------------------------------
// pvkdm_ctrl
// Sequencer: accepts a request, steps the microprogram, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pvkdm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_restart,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pvkdm_pkg::dp_cmd_t      cmd,
  input  wire pvkdm_pkg::dp_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic       out_valid_r, out_valid_nxt;
  pvkdm_pkg::uop_t uop;

  assign uop       = pvkdm_pkg::prog(pc_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.start     = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.uop       = uop;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = in_restart ? S_DONE : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (uop.op == pvkdm_pkg::OP_END) begin
          state_nxt = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.done) begin
          pc_nxt    = pc_r + 6'd1;
          state_nxt = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/pvkdm_dp.sv
// ----------------------------------------------------------------------------
// pvkdm_dp
// Datapath: register file, sequential multiplier and divider, history ring.
// ----------------------------------------------------------------------------
`default_nettype none

module pvkdm_dp #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic signed [31:0] in_accel,
  input  wire logic signed [31:0] in_meas,
  input  wire logic [15:0]        in_dt,
  input  wire logic               in_restart,
  input  wire pvkdm_pkg::dp_cmd_t cmd,
  output pvkdm_pkg::dp_sts_t      sts,
  output logic signed [31:0]      out_position,
  output logic signed [31:0]      out_velocity,
  output logic [31:0]             out_pos_variance,
  output logic [31:0]             out_vel_variance,
  output logic                    out_gain_fault
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = ((AW > 4) ? AW : 4) + 1;

  pvkdm_pkg::wide_t rf_r [pvkdm_pkg::NREG];

  logic [31:0] su_r, sm_r, ipv_r, ivv_r;
  logic [3:0]  delay_r;

  logic                     busy_r, done_r, fault_r, dzero_r, ref_valid_r, neg_r;
  logic [3:0]               op_r;
  logic [4:0]               d_r;
  pvkdm_pkg::wide_t         a_r, b_r;
  logic [63:0]              ma_r, mb_r, q_r, rem_r;
  logic [127:0]             acc_r;
  logic [6:0]               cnt_r;
  logic [AW-1:0]            ws_r;
  logic [HISTORY_DEPTH-1:0] valid_r;

  pvkdm_pkg::wide_t opa, opb;
  logic [CW-1:0]    dclip, rsum;
  logic [AW-1:0]    rd_addr, ram_addr;
  logic [31:0]      ram_rdata;
  logic             ring_we;
  logic [31:0]      la, lb;
  logic [63:0]      pp;
  logic [127:0]     pp_sh, rnd;
  logic [111:0]     rq;
  pvkdm_pkg::wide_t mres, dres, refv;
  logic [64:0]      rem2;

  assign opa = rf_r[cmd.uop.a];
  assign opb = rf_r[cmd.uop.b];

  always_comb begin
    dclip = (CW'(delay_r) > CW'(HISTORY_DEPTH - 1)) ? CW'(HISTORY_DEPTH - 1) : CW'(delay_r);
    rsum  = CW'(ws_r) + CW'(HISTORY_DEPTH) - dclip;
    if (rsum >= CW'(HISTORY_DEPTH)) begin
      rsum = rsum - CW'(HISTORY_DEPTH);
    end
    rd_addr = rsum[AW-1:0];
  end

  assign ring_we  = busy_r && (op_r == pvkdm_pkg::OP_RINGWR);
  assign ram_addr = ring_we ? ws_r : rd_addr;

  pvkdm_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .re    (cmd.load),
    .addr  (ram_addr),
    .wdata (rf_r[pvkdm_pkg::R_POS][31:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    la = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    lb = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = la * lb;
    case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rnd = acc_r + 128'd32768;
    rq  = rnd[127:16];
    if (rq > 112'(pvkdm_pkg::WMAX)) begin
      mres = pvkdm_pkg::WMAX;
    end else begin
      mres = pvkdm_pkg::wide_t'(rq[63:0]);
    end
    if (neg_r) begin
      mres = -mres;
    end
    dres = neg_r ? -pvkdm_pkg::wide_t'(q_r) : pvkdm_pkg::wide_t'(q_r);
    rem2 = {rem_r, q_r[63]};
    if (dzero_r) begin
      refv = rf_r[pvkdm_pkg::R_POS];
    end else if (ref_valid_r) begin
      refv = pvkdm_pkg::wide_t'(signed'(ram_rdata));
    end else begin
      refv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_r    <= 32'd65536;
      sm_r    <= 32'd65536;
      delay_r <= '0;
      ipv_r   <= '0;
      ivv_r   <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      fault_r <= 1'b0;
      ws_r    <= '0;
      valid_r <= '0;
      for (int i = 0; i < pvkdm_pkg::NREG; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      done_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pvkdm_pkg::CFG_INPUT_SIGMA: su_r    <= cfg_data;
          pvkdm_pkg::CFG_MEAS_SIGMA:  sm_r    <= cfg_data;
          pvkdm_pkg::CFG_DELAY:       delay_r <= cfg_data[3:0];
          pvkdm_pkg::CFG_INIT_POS:    ipv_r   <= cfg_data;
          pvkdm_pkg::CFG_INIT_VEL:    ivv_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        fault_r <= 1'b0;
        if (in_restart) begin
          rf_r[pvkdm_pkg::R_POS] <= '0;
          rf_r[pvkdm_pkg::R_VEL] <= '0;
          rf_r[pvkdm_pkg::R_P01] <= '0;
          rf_r[pvkdm_pkg::R_P10] <= '0;
          rf_r[pvkdm_pkg::R_P00] <= {32'd0, ipv_r};
          rf_r[pvkdm_pkg::R_P11] <= {32'd0, ivv_r};
          ws_r    <= '0;
          valid_r <= '0;
        end else begin
          rf_r[pvkdm_pkg::R_DT]   <= {48'd0, in_dt};
          rf_r[pvkdm_pkg::R_U]    <= pvkdm_pkg::wide_t'(in_accel);
          rf_r[pvkdm_pkg::R_Z]    <= pvkdm_pkg::wide_t'(in_meas);
          rf_r[pvkdm_pkg::R_HALF] <= pvkdm_pkg::ONE_HALF;
          rf_r[pvkdm_pkg::R_SU]   <= {32'd0, su_r};
          rf_r[pvkdm_pkg::R_SM]   <= {32'd0, sm_r};
          dzero_r     <= (dclip == '0);
          ref_valid_r <= valid_r[rd_addr];
        end
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        op_r   <= cmd.uop.op;
        d_r    <= cmd.uop.d;
        a_r    <= opa;
        b_r    <= opb;
        ma_r   <= (opa < 0) ? 64'(-opa) : 64'(opa);
        mb_r   <= (opb < 0) ? 64'(-opb) : 64'(opb);
        neg_r  <= (cmd.uop.op == pvkdm_pkg::OP_DIV) ? (opa < 0) : ((opa < 0) != (opb < 0));
        cnt_r  <= '0;
        acc_r  <= '0;
      end else if (busy_r) begin
        case (op_r)
          pvkdm_pkg::OP_MUL: begin
            if (cnt_r < 7'd4) begin
              acc_r <= acc_r + pp_sh;
              cnt_r <= cnt_r + 7'd1;
            end else begin
              rf_r[d_r] <= mres;
              busy_r    <= 1'b0;
              done_r    <= 1'b1;
            end
          end
          pvkdm_pkg::OP_DIV: begin
            if (cnt_r == 7'd0) begin
              if (b_r == '0) begin
                rf_r[d_r] <= '0;
                fault_r   <= 1'b1;
                busy_r    <= 1'b0;
                done_r    <= 1'b1;
              end else begin
                q_r   <= (ma_r << 16) + (mb_r >> 1);
                rem_r <= '0;
                cnt_r <= 7'd1;
              end
            end else if (cnt_r <= 7'd64) begin
              if (rem2 >= {1'b0, mb_r}) begin
                rem_r <= 64'(rem2 - {1'b0, mb_r});
                q_r   <= {q_r[62:0], 1'b1};
              end else begin
                rem_r <= rem2[63:0];
                q_r   <= {q_r[62:0], 1'b0};
              end
              cnt_r <= cnt_r + 7'd1;
            end else begin
              rf_r[d_r] <= dres;
              busy_r    <= 1'b0;
              done_r    <= 1'b1;
            end
          end
          pvkdm_pkg::OP_ADD:   rf_r[d_r] <= pvkdm_pkg::clampw(a_r + b_r);
          pvkdm_pkg::OP_SUB:   rf_r[d_r] <= pvkdm_pkg::clampw(a_r - b_r);
          pvkdm_pkg::OP_SATS:  rf_r[d_r] <= pvkdm_pkg::sats(a_r);
          pvkdm_pkg::OP_SATU:  rf_r[d_r] <= pvkdm_pkg::satu(a_r);
          pvkdm_pkg::OP_LDREF: rf_r[d_r] <= refv;
          pvkdm_pkg::OP_RINGWR: begin
            valid_r[ws_r] <= 1'b1;
            ws_r <= (ws_r == AW'(HISTORY_DEPTH - 1)) ? '0 : ws_r + AW'(1);
          end
          default: ;
        endcase
        if (op_r != pvkdm_pkg::OP_MUL && op_r != pvkdm_pkg::OP_DIV) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_position     <= rf_r[pvkdm_pkg::R_POS][31:0];
      out_velocity     <= rf_r[pvkdm_pkg::R_VEL][31:0];
      out_pos_variance <= rf_r[pvkdm_pkg::R_P00][31:0];
      out_vel_variance <= rf_r[pvkdm_pkg::R_P11][31:0];
      out_gain_fault   <= fault_r;
    end
  end

endmodule

`default_nettype wire

// File: src/pos_vel_kalman_delayed_meas_top.sv
// ----------------------------------------------------------------------------
// pos_vel_kalman_delayed_meas_top
// Two-state Kalman filter with delayed position measurement, Q16.16.
// Each request runs the microprogram: 25 multiplies on one 32x32 multiplier, two
// bit-serial divides and 33 short ops; a restart request skips the microprogram
// and goes straight to the result. One request is in work at a time; the result
// register lets the next request enter while a result waits. Reset clears state,
// covariance, history valid bits and config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pos_vel_kalman_delayed_meas_top #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pvkdm_in_if.sink         in_if,
  pvkdm_out_if.source      out_if,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  pvkdm_pkg::dp_cmd_t cmd;
  pvkdm_pkg::dp_sts_t sts;

  pvkdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_restart (in_if.restart),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pvkdm_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_accel         (in_if.accel_input),
    .in_meas          (in_if.measured_position),
    .in_dt            (in_if.time_step),
    .in_restart       (in_if.restart),
    .cmd              (cmd),
    .sts              (sts),
    .out_position     (out_if.position),
    .out_velocity     (out_if.velocity),
    .out_pos_variance (out_if.pos_variance),
    .out_vel_variance (out_if.vel_variance),
    .out_gain_fault   (out_if.gain_fault)
  );

endmodule

`default_nettype wire
